>>> rtl/imu_frame_deframer_crc16_macros.svh
// Assertion macros used by the checker module of the IMU frame deframer.
`ifndef IMU_FRAME_DEFRAMER_CRC16_MACROS_SVH
`define IMU_FRAME_DEFRAMER_CRC16_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMUFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imufd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IMUFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imufd assertion failed");

`endif

>>> rtl/imufd_pkg.sv
// Types, constants and CRC function of the IMU frame deframer.
package imufd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
    localparam logic [7:0]  SYNC_SECOND = 8'hA5;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_TOP     = 16'h8000;

    localparam int N_ACC   = 12;
    localparam int N_GYR   = 12;
    localparam int N_QAT   = 16;
    localparam int N_WORDS = 10;
    localparam int IDX_W   = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_WORDS - 1);

    // Register map: word index of each configuration register.
    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_GYRO  = 2'd1;
    localparam logic [1:0] REG_QUAT  = 2'd2;

    localparam logic [15:0] RST_ACCEL_OFF = 16'd12;
    localparam logic [15:0] RST_GYRO_OFF  = 16'd24;
    localparam logic [15:0] RST_QUAT_OFF  = 16'd60;

    typedef struct packed {
        logic [15:0] accel;
        logic [15:0] gyro;
        logic [15:0] quat;
    } t_offsets;

    typedef struct packed {
        logic    fire;
        t_status status;
    } t_frame_evt;

    typedef logic [N_WORDS-1:0][31:0] t_words;

    // CRC-16, MSB first, one byte per call.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_SYNC = crc_byte(crc_byte(16'h0000, SYNC_FIRST), SYNC_SECOND);

endpackage

>>> rtl/imufd_if.sv
// Valid/ready channel interfaces for input bytes and result words.
interface imufd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufd_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [3:0]  word_index;
    logic [1:0]  frame_status;
    logic        last_word;

    modport source (output valid, output data_word, output word_index,
                    output frame_status, output last_word, input ready);
    modport sink   (input valid, input data_word, input word_index,
                    input frame_status, input last_word, output ready);
endinterface

>>> rtl/imufd_regs.sv
// APB-style configuration registers holding the three capture offsets.
module imufd_regs
    import imufd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_offsets    o_offsets
);

    t_offsets   r_offsets;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_sel   = paddr[3:2];
    assign o_offsets = r_offsets;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offsets.accel <= RST_ACCEL_OFF;
            r_offsets.gyro  <= RST_GYRO_OFF;
            r_offsets.quat  <= RST_QUAT_OFF;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_ACCEL: r_offsets.accel <= pwdata[15:0];
                REG_GYRO:  r_offsets.gyro  <= pwdata[15:0];
                REG_QUAT:  r_offsets.quat  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ACCEL: prdata = {16'h0000, r_offsets.accel};
            REG_GYRO:  prdata = {16'h0000, r_offsets.gyro};
            REG_QUAT:  prdata = {16'h0000, r_offsets.quat};
            default:   prdata = 32'h0000_0000;
        endcase
    end

endmodule

>>> rtl/imufd_parser.sv
// Frame parser: sync hunt, header fields, CRC, capture store and end-of-frame check.
module imufd_parser
    import imufd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [7:0] i_byte,
    input  t_offsets   i_offsets,
    output logic       o_end_pending,
    output t_frame_evt o_evt,
    output t_words     o_words
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_fcrc, n_fcrc;

    logic [N_ACC-1:0][7:0] r_acc, n_acc;
    logic [N_GYR-1:0][7:0] r_gyr, n_gyr;
    logic [N_QAT-1:0][7:0] r_qat, n_qat;

    logic [15:0] crc_upd;
    logic [15:0] d_acc, d_gyr, d_qat;
    logic        hit_acc, hit_gyr, hit_qat;
    logic        fire;
    logic        fit_acc, fit_gyr, fit_qat;
    t_status     status;

    assign crc_upd = crc_byte(r_crc, i_byte);

    // Position of the current payload byte inside each group.
    assign d_acc   = r_cnt - i_offsets.accel;
    assign d_gyr   = r_cnt - i_offsets.gyro;
    assign d_qat   = r_cnt - i_offsets.quat;
    assign hit_acc = (r_cnt >= i_offsets.accel) && (d_acc < 16'(N_ACC));
    assign hit_gyr = (r_cnt >= i_offsets.gyro)  && (d_gyr < 16'(N_GYR));
    assign hit_qat = (r_cnt >= i_offsets.quat)  && (d_qat < 16'(N_QAT));

    // Next accepted byte closes a frame; known from state alone.
    assign o_end_pending = ((r_phase == PH_CRC_HI) && (r_len == 16'h0000)) ||
                           ((r_phase == PH_PAYLOAD) && ((r_cnt + 16'd1) == r_len));

    // Phase sequencing.
    always_comb begin
        n_phase = r_phase;
        if (i_acc) begin
            unique case (r_phase)
                PH_HUNT1: begin
                    if (i_byte == SYNC_FIRST) n_phase = PH_HUNT2;
                end
                PH_HUNT2: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_phase = PH_LEN_LO;
                    end else if (i_byte != SYNC_FIRST) begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_LEN_LO: n_phase = PH_LEN_HI;
                PH_LEN_HI: n_phase = PH_CRC_LO;
                PH_CRC_LO: n_phase = PH_CRC_HI;
                PH_CRC_HI: n_phase = (r_len == 16'h0000) ? PH_HUNT1 : PH_PAYLOAD;
                PH_PAYLOAD: begin
                    if ((r_cnt + 16'd1) == r_len) n_phase = PH_HUNT1;
                end
                default: n_phase = PH_HUNT1;
            endcase
        end
    end

    // Header fields, CRC, capture writes and frame-end event.
    always_comb begin
        n_cnt  = r_cnt;
        n_len  = r_len;
        n_crc  = r_crc;
        n_fcrc = r_fcrc;
        n_acc  = r_acc;
        n_gyr  = r_gyr;
        n_qat  = r_qat;
        fire   = 1'b0;
        if (i_acc) begin
            unique case (r_phase)
                PH_HUNT2: begin
                    if (i_byte == SYNC_SECOND) n_crc = CRC_SYNC;
                end
                PH_LEN_LO: begin
                    n_len = {8'h00, i_byte};
                    n_crc = crc_upd;
                end
                PH_LEN_HI: begin
                    n_len = {i_byte, r_len[7:0]};
                    n_crc = crc_upd;
                end
                PH_CRC_LO: n_fcrc = {8'h00, i_byte};
                PH_CRC_HI: begin
                    n_fcrc = {i_byte, r_fcrc[7:0]};
                    n_cnt  = 16'h0000;
                    fire   = (r_len == 16'h0000);
                end
                PH_PAYLOAD: begin
                    n_crc = crc_upd;
                    if (hit_acc) n_acc[d_acc[3:0]] = i_byte;
                    if (hit_gyr) n_gyr[d_gyr[3:0]] = i_byte;
                    if (hit_qat) n_qat[d_qat[3:0]] = i_byte;
                    n_cnt = r_cnt + 16'd1;
                    fire  = (n_cnt == r_len);
                end
                default: ;
            endcase
        end
    end

    // Groups must lie inside the payload; sums kept at 17 bits, no wrap.
    assign fit_acc = ({1'b0, i_offsets.accel} + 17'(N_ACC)) <= {1'b0, n_len};
    assign fit_gyr = ({1'b0, i_offsets.gyro}  + 17'(N_GYR)) <= {1'b0, n_len};
    assign fit_qat = ({1'b0, i_offsets.quat}  + 17'(N_QAT)) <= {1'b0, n_len};

    always_comb begin
        priority if (n_crc != n_fcrc) begin
            status = ST_CRC;
        end else if (!(fit_acc && fit_gyr && fit_qat)) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    assign o_evt.fire   = fire;
    assign o_evt.status = status;
    assign o_words      = t_words'({n_qat, n_gyr, n_acc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_cnt   <= 16'h0000;
            r_len   <= 16'h0000;
            r_crc   <= 16'h0000;
            r_fcrc  <= 16'h0000;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_fcrc  <= n_fcrc;
        end
    end

    // Capture store carries no reset.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_gyr <= n_gyr;
        r_qat <= n_qat;
    end

endmodule

>>> rtl/imufd_drain.sv
// Result buffer: holds one frame's words and hands them out one per handshake.
module imufd_drain
    import imufd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_evt  i_evt,
    input  t_words      i_words,
    input  logic        i_ready,
    output logic        o_busy,
    output logic        o_valid,
    output logic [31:0] o_data_word,
    output logic [3:0]  o_word_index,
    output logic [1:0]  o_frame_status,
    output logic        o_last_word
);

    t_words           r_buf;
    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    t_status          r_status;
    logic             last;

    assign last           = (r_status != ST_OK) || (r_idx == LAST_IDX);
    assign o_busy         = r_valid;
    assign o_valid        = r_valid;
    assign o_data_word    = (r_status == ST_OK) ? r_buf[r_idx] : 32'h0000_0000;
    assign o_word_index   = r_idx;
    assign o_frame_status = r_status;
    assign o_last_word    = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_idx    <= '0;
            r_status <= ST_OK;
        end else if (i_evt.fire) begin
            r_valid  <= 1'b1;
            r_idx    <= '0;
            r_status <= i_evt.status;
        end else if (r_valid && i_ready) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Snapshot the capture store; only ok frames need it.
    always_ff @(posedge i_clk) begin
        if (i_evt.fire && (i_evt.status == ST_OK)) begin
            r_buf <= i_words;
        end
    end

endmodule

>>> rtl/imu_frame_deframer_crc16.sv
// A frame's first result word is valid in the cycle after its closing byte is accepted.
// Throughput: one byte per cycle while the input is ready; an ok frame drains ten words,
// one per output handshake. A frame-closing byte is held off while the previous
// frame's words are still pending, so a frame ending before they drain stalls the input.
// Reset: synchronous, active low; clears parser state and restores default offsets.
// The 40-byte capture store and the result buffer are not reset.
module imu_frame_deframer_crc16
    import imufd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    imufd_byte_if.sink   i_rx,
    imufd_res_if.source  o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_offsets   offsets;
    t_frame_evt evt;
    t_words     words;
    logic       end_pending;
    logic       drain_busy;
    logic       rx_acc;

    // Offsets are read live: capture uses those in force as each byte arrives.
    imufd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_offsets (offsets)
    );

    // Hold the input only when the next byte would end a frame and the buffer is full.
    assign i_rx.ready = !(end_pending && drain_busy);
    assign rx_acc     = i_rx.valid && i_rx.ready;

    // Parser: sync hunt, header, CRC and capture, all in the accepting cycle.
    imufd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (rx_acc),
        .i_byte        (i_rx.rx_byte),
        .i_offsets     (offsets),
        .o_end_pending (end_pending),
        .o_evt         (evt),
        .o_words       (words)
    );

    // Result buffer parts the input side from output stalls.
    imufd_drain u_drain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (evt),
        .i_words        (words),
        .i_ready        (o_res.ready),
        .o_busy         (drain_busy),
        .o_valid        (o_res.valid),
        .o_data_word    (o_res.data_word),
        .o_word_index   (o_res.word_index),
        .o_frame_status (o_res.frame_status),
        .o_last_word    (o_res.last_word)
    );

endmodule

>>> rtl/imufd_checker.sv
// Port-level checker for the IMU frame deframer and its bind statement.
`include "imu_frame_deframer_crc16_macros.svh"

module imufd_checker
    import imufd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_data_word,
    input logic [3:0]  i_word_index,
    input logic [1:0]  i_frame_status,
    input logic        i_last_word
);

    // An error frame gives exactly one zeroed result.
    `IMUFD_ASSERT_IMP(a_err_single, i_clk, i_rst_n, i_res_valid && (i_frame_status != ST_OK), i_last_word && (i_data_word == 32'h0) && (i_word_index == 4'h0))

    // An ok frame ends on its tenth word.
    `IMUFD_ASSERT_IMP(a_ok_last, i_clk, i_rst_n, i_res_valid && (i_frame_status == ST_OK) && i_last_word, i_word_index == LAST_IDX)

    // Words of one frame follow in order with no gap.
    `IMUFD_ASSERT_NXT(a_idx_step, i_clk, i_rst_n, i_res_valid && i_res_ready && !i_last_word, i_res_valid && (i_word_index == ($past(i_word_index) + 4'd1)))

    // A stalled word holds.
    `IMUFD_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_data_word) && $stable(i_word_index))

endmodule

bind imu_frame_deframer_crc16 imufd_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_data_word    (o_res.data_word),
    .i_word_index   (o_res.word_index),
    .i_frame_status (o_res.frame_status),
    .i_last_word    (o_res.last_word)
);

>>> tb/sv/imu_frame_deframer_crc16_tb.sv
// Self-checking testbench of the IMU frame deframer: byte stream in, checked result words out.
module imu_frame_deframer_crc16_tb;
    import imufd_pkg::*;

    // Payload fill styles for generated frames.
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_EXTREME = 1;

    // Register index that maps to no register; writes to it must be dropped.
    localparam logic [1:0] REG_BAD = 2'd3;

    // Generated frames are only made well-formed when they stay this short.
    localparam int OK_LEN_CAP = 200;
    localparam int SHORT_LEN_CAP = 40;

    // Cycles to let pass after the last word before touching a register.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT = 5000;
    localparam int RUN_LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic [31:0] data;
        logic [3:0]  idx;
        t_status     status;
        logic        last;
    } frame_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    imufd_byte_if rx_if();
    imufd_res_if  res_if();

    // Bytes still to be offered, and words the deframer still owes us.
    logic [7:0]  rx_stream[$];
    frame_word_t exp_words[$];

    // Idle odds of each side, in percent.
    int tx_idle_pct;
    int rx_idle_pct;

    // Our own copy of the offsets and of the parser.
    logic [15:0] cfg_accel = RST_ACCEL_OFF;
    logic [15:0] cfg_gyro  = RST_GYRO_OFF;
    logic [15:0] cfg_quat  = RST_QUAT_OFF;
    t_phase      parse_state = PH_HUNT1;
    int          pay_cnt = 0;
    logic [15:0] frame_len = 16'h0000;
    logic [15:0] run_crc = 16'h0000;
    logic [15:0] rx_crc = 16'h0000;
    logic [7:0]  cap_store[N_ACC + N_GYR + N_QAT];

    int errors = 0;
    int n_bytes_queued = 0;
    int n_bytes_in = 0;
    int n_words_out = 0;
    int n_ok = 0;
    int n_crc_err = 0;
    int n_short = 0;
    int n_cfg_writes = 0;

    imu_frame_deframer_crc16 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // CRC-16/XMODEM, one bit at a time, MSB of the byte first.
    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Store a payload byte if it falls inside a group's window.
    task automatic capture_group(input logic [15:0] off, input int size, input int base,
                                 input logic [7:0] b);
        int lo;
        lo = int'(off);
        if (pay_cnt >= lo && pay_cnt < lo + size) begin
            cap_store[base + pay_cnt - lo] = b;
        end
    endtask

    // Judge the frame that just closed and queue the words it must produce.
    task automatic close_frame();
        t_status     st;
        frame_word_t w;
        parse_state = PH_HUNT1;
        st = ST_OK;
        // A CRC mismatch wins over a payload too short for the groups.
        if (run_crc != rx_crc) begin
            st = ST_CRC;
        end else if (int'(cfg_accel) + N_ACC > int'(frame_len) ||
                     int'(cfg_gyro) + N_GYR > int'(frame_len) ||
                     int'(cfg_quat) + N_QAT > int'(frame_len)) begin
            st = ST_SHORT;
        end
        if (st != ST_OK) begin
            w = '{data: 32'h0, idx: 4'd0, status: st, last: 1'b1};
            exp_words.push_back(w);
            if (st == ST_CRC) begin
                n_crc_err++;
            end else begin
                n_short++;
            end
        end else begin
            for (int k = 0; k < N_WORDS; k++) begin
                w.data   = {cap_store[4*k+3], cap_store[4*k+2],
                            cap_store[4*k+1], cap_store[4*k]};
                w.idx    = 4'(k);
                w.status = ST_OK;
                w.last   = (k == N_WORDS - 1);
                exp_words.push_back(w);
            end
            n_ok++;
        end
    endtask

    // Advance the parser copy by one accepted byte.
    task automatic deframe_byte(input logic [7:0] b);
        case (parse_state)
            PH_HUNT1: begin
                if (b == SYNC_FIRST) begin
                    parse_state = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                // A repeated first sync byte keeps us waiting for the second one.
                if (b == SYNC_SECOND) begin
                    run_crc = crc16_step(crc16_step(16'h0000, SYNC_FIRST), SYNC_SECOND);
                    parse_state = PH_LEN_LO;
                end else if (b != SYNC_FIRST) begin
                    parse_state = PH_HUNT1;
                end
            end
            PH_LEN_LO: begin
                frame_len = {8'h00, b};
                run_crc = crc16_step(run_crc, b);
                parse_state = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frame_len[15:8] = b;
                run_crc = crc16_step(run_crc, b);
                parse_state = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                rx_crc = {8'h00, b};
                parse_state = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                rx_crc[15:8] = b;
                pay_cnt = 0;
                // An empty payload closes the frame right here.
                if (frame_len == 16'h0000) begin
                    close_frame();
                end else begin
                    parse_state = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                run_crc = crc16_step(run_crc, b);
                capture_group(cfg_accel, N_ACC, 0, b);
                capture_group(cfg_gyro, N_GYR, N_ACC, b);
                capture_group(cfg_quat, N_QAT, N_ACC + N_GYR, b);
                pay_cnt = (pay_cnt + 1) & 32'h0000_FFFF;
                if (pay_cnt == int'(frame_len)) begin
                    close_frame();
                end
            end
            default: begin
                parse_state = PH_HUNT1;
            end
        endcase
    endtask

    // Queue one whole frame: sync pair, length, CRC, payload.
    task automatic push_frame(input int len, input bit bad_crc, input int fill);
        logic [15:0] c;
        logic [7:0]  b;
        logic [7:0]  body[$];
        c = crc16_step(crc16_step(16'h0000, SYNC_FIRST), SYNC_SECOND);
        c = crc16_step(c, len[7:0]);
        c = crc16_step(c, len[15:8]);
        for (int i = 0; i < len; i++) begin
            if (fill == FILL_EXTREME) begin
                b = (i % 2 != 0) ? 8'hFF : 8'h00;
            end else begin
                b = 8'($urandom);
            end
            body.push_back(b);
            c = crc16_step(c, b);
        end
        // Flip one CRC bit so the check is sure to fail.
        if (bad_crc) begin
            c = c ^ 16'(1 << $urandom_range(15));
        end
        rx_stream.push_back(SYNC_FIRST);
        rx_stream.push_back(SYNC_SECOND);
        rx_stream.push_back(len[7:0]);
        rx_stream.push_back(len[15:8]);
        rx_stream.push_back(c[7:0]);
        rx_stream.push_back(c[15:8]);
        foreach (body[i]) begin
            rx_stream.push_back(body[i]);
        end
        n_bytes_queued += 6 + len;
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_stream.push_back(b);
        n_bytes_queued++;
    endtask

    // Write one register over APB: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // Scramble the upper half: only the low 16 bits belong to a register.
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ACCEL: cfg_accel = val;
            REG_GYRO:  cfg_gyro  = val;
            REG_QUAT:  cfg_quat  = val;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic wait_input_done();
        while (rx_stream.size() != 0 || rx_if.valid) begin
            @(posedge i_clk);
        end
    endtask

    // Bring the block to idle: feed out any open frame, drain the words, then pause.
    task automatic settle();
        int waited;
        wait_input_done();
        // Pad an open frame with zero bytes so the next offsets apply to whole frames.
        while (parse_state inside {PH_LEN_LO, PH_LEN_HI, PH_CRC_LO, PH_CRC_HI, PH_PAYLOAD}) begin
            push_byte(8'h00);
            wait_input_done();
        end
        waited = 0;
        while (exp_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (exp_words.size() != 0) begin
            $display("%0t: %0d expected words never arrived, oldest data=%08h idx=%0d",
                     $time, exp_words.size(), exp_words[0].data, exp_words[0].idx);
            errors++;
            exp_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Set the offsets, then stream frames and noise, mostly well-formed if need <= OK_LEN_CAP.
    task automatic random_phase(input logic [15:0] a, input logic [15:0] g,
                                input logic [15:0] q, input int budget);
        int start;
        int need;
        int r;
        int len;
        int n;
        logic [7:0] b;
        write_reg(REG_ACCEL, a);
        write_reg(REG_GYRO, g);
        write_reg(REG_QUAT, q);
        // Smallest payload that holds every group, reckoned without wrap.
        need = int'(cfg_accel) + N_ACC;
        if (int'(cfg_gyro) + N_GYR > need) begin
            need = int'(cfg_gyro) + N_GYR;
        end
        if (int'(cfg_quat) + N_QAT > need) begin
            need = int'(cfg_quat) + N_QAT;
        end
        start = n_bytes_queued;
        while (n_bytes_queued - start < budget) begin
            r = $urandom_range(99);
            if (r < 60 && need <= OK_LEN_CAP) begin
                push_frame(need + $urandom_range(6), 1'b0, FILL_RANDOM);
            end else if (r < 72) begin
                len = (need > OK_LEN_CAP) ? $urandom_range(SHORT_LEN_CAP)
                                          : $urandom_range(need + 4);
                push_frame(len, 1'b1, FILL_RANDOM);
            end else if (r < 82) begin
                len = (need > OK_LEN_CAP) ? $urandom_range(SHORT_LEN_CAP)
                                          : $urandom_range(need - 1);
                push_frame(len, 1'b0, FILL_RANDOM);
            end else if (r < 92) begin
                // Line noise: never a first sync byte, so nothing starts.
                n = $urandom_range(1, 6);
                repeat (n) begin
                    b = 8'($urandom);
                    if (b == SYNC_FIRST) begin
                        b = b ^ 8'h01;
                    end
                    push_byte(b);
                end
            end else if (r < 96) begin
                // Broken sync: first byte followed by a byte that restarts the hunt.
                push_byte(SYNC_FIRST);
                push_byte(8'h00);
            end else begin
                // Doubled first sync byte ahead of a frame.
                push_byte(SYNC_FIRST);
                len = (need > OK_LEN_CAP) ? $urandom_range(SHORT_LEN_CAP) : need;
                push_frame(len, 1'b0, FILL_RANDOM);
            end
        end
        settle();
    endtask

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Byte driver: offer the next queued byte, and run the parser copy on each accepted byte.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_if.ready) begin
            if (rx_if.valid) begin
                deframe_byte(rx_if.rx_byte);
                n_bytes_in++;
            end
            if (rx_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= rx_stream.pop_front();
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: stall at random, compare each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        frame_word_t got;
        frame_word_t want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            if (res_if.valid && res_if.ready) begin
                got.data   = res_if.data_word;
                got.idx    = res_if.word_index;
                got.status = t_status'(res_if.frame_status);
                got.last   = res_if.last_word;
                n_words_out++;
                if (exp_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, ", $time,
                             "actual data=%08h idx=%0d status=%0d last=%0d",
                             got.data, got.idx, got.status, got.last);
                    errors++;
                end else begin
                    want = exp_words.pop_front();
                    if (got.data !== want.data || got.idx !== want.idx ||
                        got.status !== want.status || got.last !== want.last) begin
                        $display("%0t: word mismatch: ", $time,
                                 "expected data=%08h idx=%0d status=%0d last=%0d, ",
                                 want.data, want.idx, want.status, want.last,
                                 "actual data=%08h idx=%0d status=%0d last=%0d",
                                 got.data, got.idx, got.status, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(12 * RUN_LIMIT_CYCLES);
        $display("%0t: run limit reached, %0d words still expected", $time, exp_words.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 4'h0;
        pwdata        = 32'h0;
        foreach (cap_store[i]) begin
            cap_store[i] = 8'h00;
        end
        // Sender rarely idles, receiver mostly stalls.
        tx_idle_pct = 7;
        rx_idle_pct = 67;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset offsets: none of these frames may read the capture store.
        push_byte(SYNC_FIRST);
        push_byte(8'h3C);            // restart the hunt
        push_byte(SYNC_SECOND);      // stray second sync byte while hunting
        push_byte(SYNC_FIRST);       // doubled first sync byte ahead of the next frame
        push_frame(0, 1'b0, FILL_RANDOM);    // empty payload, CRC good: too short
        push_frame(0, 1'b1, FILL_RANDOM);    // empty payload, CRC bad: CRC wins
        push_frame(3, 1'b0, FILL_EXTREME);   // short payload
        settle();

        // Directed, all groups at offset zero: smallest frame that fills the store.
        write_reg(REG_ACCEL, 16'h0000);
        write_reg(REG_GYRO, 16'h0000);
        write_reg(REG_QUAT, 16'h0000);
        write_reg(REG_BAD, 16'($urandom));  // must leave every offset alone
        push_frame(16, 1'b0, FILL_EXTREME);
        push_frame(16, 1'b0, FILL_RANDOM);
        settle();

        random_phase(RST_ACCEL_OFF, RST_GYRO_OFF, RST_QUAT_OFF, 25);
        random_phase(16'($urandom_range(24)), 16'($urandom_range(24)),
                     16'($urandom_range(24)), 20);

        // Swap the idle odds.
        tx_idle_pct = 67;
        rx_idle_pct = 7;
        random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 20);
        write_reg(REG_BAD, 16'h0000);
        random_phase(16'($urandom_range(24)), 16'($urandom_range(24)),
                     16'($urandom_range(24)), 20);

        // Full speed on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(16'($urandom_range(24)), 16'($urandom_range(24)),
                     16'($urandom_range(24)), 20);
        random_phase(16'd65523, 16'd65519, 16'd65519, 15);

        $display("Streamed %0d bytes over %0d register writes; checked %0d result words.",
                 n_bytes_in, n_cfg_writes, n_words_out);
        $display("Frames judged: %0d ok, %0d CRC mismatch, %0d payload too short; %0d errors.",
                 n_ok, n_crc_err, n_short, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/imufd_pkg.sv
rtl/imufd_if.sv
rtl/imufd_regs.sv
rtl/imufd_parser.sv
rtl/imufd_drain.sv
rtl/imu_frame_deframer_crc16.sv
rtl/imufd_checker.sv
tb/sv/imu_frame_deframer_crc16_tb.sv
